>>> hdl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg - shared types and helpers for the HSV to RGB converter
// Color sector codes, level widths and the ceil(x/255) helper.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int unsigned LevelW = 8;
	localparam int unsigned ProdW  = 2 * LevelW;
	localparam int unsigned H6W    = 11;

	localparam logic [LevelW-1:0] FULL_LEVEL = 8'd255;

	typedef logic [LevelW-1:0] level_t;
	typedef logic [ProdW-1:0]  prod_t;

	// sixths of the color circle
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// ceil(x/255) for x <= 255*255, via floor(y/255) = (y + (y>>8) + 1) >> 8
	function automatic level_t ceil_div255(input prod_t x);
		logic [ProdW:0] y;
		logic [ProdW:0] s;
		begin
			y = {1'b0, x} + (ProdW+1)'(254);
			s = y + (y >> 8) + (ProdW+1)'(1);
			ceil_div255 = s[ProdW-1:8];
		end
	endfunction

endpackage

>>> hdl/hsv_to_rgb_full_value_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_full_value_core - HSV to RGB at full value, streaming
// Three-stage pipeline converting 8-bit hue/saturation into 8-bit RGB.
// ----------------------------------------------------------------------------
// Converts one (hue, saturation) item into one (red, green, blue) item with
// the value fixed at full scale. Hue 0..255 covers the whole color circle,
// hue 255 lands back on pure red like hue 0, and saturation 0 gives white.
// Levels are exact integers, truncated toward zero. Throughput is one item
// per clock while m_tready is high. The accepting edge loads stage 1, and the
// item then moves through stage 2 into the output register behind m_tvalid.
// Stage 1 scales the hue by six and finds the sector and its fraction, stage 2
// runs the two 8x8 multiplies, stage 3 divides by 255 with a reciprocal and
// routes the levels to the channels into the output register. Each stage holds
// its item while the stage after it is full and stalled, so back-pressure on
// m_tready costs no item and repeats none.
module hsv_to_rgb_full_value_core
	import hsv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] hue, [15:8] saturation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

	// stage valid bits
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	// stage 1: sector and fraction
	sector_t sector_s1;
	level_t  fn_s1;
	level_t  sat_s1;

	// stage 2: products
	sector_t sector_s2;
	prod_t   qx_s2;    // fn * sat
	prod_t   tx_s2;    // (255 - fn) * sat
	level_t  sat_s2;

	// stage 3: output register
	level_t  red_s3, green_s3, blue_s3;

	// stage 1 combinational
	level_t         hue_in, sat_in;
	logic [H6W-1:0] h6;
	sector_t        sector_c;
	logic [H6W-1:0] base_c;
	level_t         fn_c;

	// stage 3 combinational
	level_t p_c, q_c, t_c;
	level_t red_c, green_c, blue_c;

	// a stage takes a new item when empty or when its item moves on
	assign rdy3     = !v_s3 || m_tready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	assign hue_in = s_tdata[7:0];
	assign sat_in = s_tdata[15:8];

	// hue*6 as shift-add
	assign h6 = ({3'b000, hue_in} << 2) + ({3'b000, hue_in} << 1);

	// sector = (h6 div 255) mod 6; the top hue wraps to sector 0 with no fraction
	always_comb begin
		priority if (h6 >= H6W'(1530)) begin
			sector_c = SEC_RED_YEL;
			base_c   = H6W'(1530);
		end else if (h6 >= H6W'(1275)) begin
			sector_c = SEC_MAG_RED;
			base_c   = H6W'(1275);
		end else if (h6 >= H6W'(1020)) begin
			sector_c = SEC_BLU_MAG;
			base_c   = H6W'(1020);
		end else if (h6 >= H6W'(765)) begin
			sector_c = SEC_CYN_BLU;
			base_c   = H6W'(765);
		end else if (h6 >= H6W'(510)) begin
			sector_c = SEC_GRN_CYN;
			base_c   = H6W'(510);
		end else if (h6 >= H6W'(255)) begin
			sector_c = SEC_YEL_GRN;
			base_c   = H6W'(255);
		end else begin
			sector_c = SEC_RED_YEL;
			base_c   = '0;
		end
	end

	always_comb begin
		logic [H6W-1:0] diff;
		diff = h6 - base_c;
		fn_c = diff[LevelW-1:0];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			sector_s1 <= sector_c;
			fn_s1     <= fn_c;
			sat_s1    <= sat_in;
		end
	end

	// stage 2 payload: the two multiplies
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			sector_s2 <= sector_s1;
			qx_s2     <= prod_t'(fn_s1) * prod_t'(sat_s1);
			tx_s2     <= prod_t'(FULL_LEVEL - fn_s1) * prod_t'(sat_s1);
			sat_s2    <= sat_s1;
		end
	end

	// stage 3: levels and channel routing
	assign p_c = FULL_LEVEL - sat_s2;
	assign q_c = FULL_LEVEL - ceil_div255(qx_s2);
	assign t_c = FULL_LEVEL - ceil_div255(tx_s2);

	always_comb begin
		unique case (sector_s2)
			SEC_RED_YEL: begin red_c = FULL_LEVEL; green_c = t_c;        blue_c = p_c;        end
			SEC_YEL_GRN: begin red_c = q_c;        green_c = FULL_LEVEL; blue_c = p_c;        end
			SEC_GRN_CYN: begin red_c = p_c;        green_c = FULL_LEVEL; blue_c = t_c;        end
			SEC_CYN_BLU: begin red_c = p_c;        green_c = q_c;        blue_c = FULL_LEVEL; end
			SEC_BLU_MAG: begin red_c = t_c;        green_c = p_c;        blue_c = FULL_LEVEL; end
			SEC_MAG_RED: begin red_c = FULL_LEVEL; green_c = p_c;        blue_c = q_c;        end
			default:     begin red_c = FULL_LEVEL; green_c = p_c;        blue_c = q_c;        end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			red_s3   <= red_c;
			green_s3 <= green_c;
			blue_s3  <= blue_c;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {blue_s3, green_s3, red_s3};

	// ---- checks ----

	// at full value one channel is always at the top level
	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (red_s3 == FULL_LEVEL || green_s3 == FULL_LEVEL ||
			blue_s3 == FULL_LEVEL))
		else $error("no channel at full level");

	// an accepted item occupies stage 1 on the next edge
	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted item lost at stage 1");

	// a stalled stage 2 keeps its item
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy3 |=> v_s2 && $stable(qx_s2) && $stable(tx_s2))
		else $error("stage 2 item changed under stall");

	// the two products always add to sat*255
	a_prod_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ({1'b0, qx_s2} + {1'b0, tx_s2}) ==
			((ProdW+1)'(sat_s2) * (ProdW+1)'(FULL_LEVEL)))
		else $error("stage 2 products inconsistent");

endmodule

>>> verif/tb_hsv_to_rgb_full_value_core.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_full_value_core - testbench for the full-value HSV to RGB core
// Sends hue/saturation items through the stream input and compares every
// red/green/blue item against an exact integer model of the conversion.
// Both stream sides idle at random, so stalls land on every pipeline stage.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_full_value_core
	import hsv_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// quiet cycles (no item moving on either side) before the run is called hung
	localparam int unsigned WatchdogLimit = 1000;
	// settle time after the last expected pixel
	localparam int unsigned DrainCycles   = 12;
	localparam int unsigned RandomPixels  = 700;
	localparam int unsigned StretchLen    = 50;

	// one output pixel, laid out like m_tdata: red lowest, blue highest
	typedef struct packed {
		level_t blue;
		level_t green;
		level_t red;
	} rgb_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [7:0] hue, [15:8] saturation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [7:0] red, [15:8] green, [23:16] blue

	rgb_t        expected_rgb_q[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit          src_idle = 1'b1;  // sender draws random gaps per item
	bit          sink_idle = 1'b1; // receiver draws random stalls per item

	always #4 clk = ~clk;

	hsv_to_rgb_full_value_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ceil(x/255), x no larger than 255*255
	function automatic int unsigned ceil_by_255(input int unsigned x);
		return (x + 254) / 255;
	endfunction

	// Expected color at full value. The hue is scaled by six: the quotient by
	// 255 picks the sixth of the circle, the remainder is the position in it.
	function automatic rgb_t hsv_full_value_color(input level_t hue, input level_t sat);
		int unsigned h6;
		int unsigned frac;
		sector_t     sixth;
		level_t      lvl_p;
		level_t      lvl_q;
		level_t      lvl_t;
		rgb_t        c;
		h6    = int'(hue) * 6;
		// hue 255 gives 1530 = 6*255, which wraps to the red sixth with no fraction
		sixth = sector_t'((h6 / 255) % 6);
		frac  = h6 % 255;
		lvl_p = FULL_LEVEL - sat;
		lvl_q = level_t'(255 - ceil_by_255(frac * int'(sat)));
		lvl_t = level_t'(255 - ceil_by_255((255 - frac) * int'(sat)));
		case (sixth)
			SEC_RED_YEL: c = '{red: FULL_LEVEL, green: lvl_t, blue: lvl_p};
			SEC_YEL_GRN: c = '{red: lvl_q, green: FULL_LEVEL, blue: lvl_p};
			SEC_GRN_CYN: c = '{red: lvl_p, green: FULL_LEVEL, blue: lvl_t};
			SEC_CYN_BLU: c = '{red: lvl_p, green: lvl_q, blue: FULL_LEVEL};
			SEC_BLU_MAG: c = '{red: lvl_t, green: lvl_p, blue: FULL_LEVEL};
			default:     c = '{red: FULL_LEVEL, green: lvl_p, blue: lvl_q};
		endcase
		return c;
	endfunction

	function automatic void compare_level(input string channel, input level_t want,
			input level_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, channel, want, got);
			mismatches++;
		end
	endfunction

	// Sends one item. Called at a falling edge, returns at the falling edge
	// after the item was taken. With no gap drawn, s_tvalid simply stays high.
	task automatic send_pixel(input level_t hue, input level_t sat);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {sat, hue};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Receiver: per output item, hold m_tready low for a randomly drawn stall, then take it.
	initial begin : sink_stalls
		int unsigned gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = sink_idle ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Input and output handshakes are sampled in one block, so an accepted
	// input is always queued before the same edge's output is checked.
	always @(posedge clk) begin : pixel_scoreboard
		rgb_t want;
		rgb_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_rgb_q.push_back(hsv_full_value_color(s_tdata[7:0], s_tdata[15:8]));
			if (m_tvalid && m_tready) begin
				got = rgb_t'(m_tdata);
				if (expected_rgb_q.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, got r=%0d g=%0d b=%0d",
						$time, got.red, got.green, got.blue);
					mismatches++;
				end else begin
					want = expected_rgb_q.pop_front();
					compare_level("red",   want.red,   got.red);
					compare_level("green", want.green, got.green);
					compare_level("blue",  want.blue,  got.blue);
				end
			end
		end
	end

	// Hang detection: any item moving on either side restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Hue ends of the range; hue 255 must come out like hue 0.
	task automatic test_hue_extremes();
		send_pixel(8'd0,   8'd255);
		send_pixel(8'd255, 8'd255);
		send_pixel(8'd1,   8'd255);
		send_pixel(8'd254, 8'd255);
		send_pixel(8'd0,   8'd0);
		send_pixel(8'd255, 8'd0);
		send_pixel(8'd1,   8'd0);
		send_pixel(8'd254, 8'd0);
	endtask

	// Walk across every sixth, on and next to the boundaries.
	task automatic test_sector_walk();
		level_t hues[7] = '{8'd42, 8'd43, 8'd85, 8'd128, 8'd170, 8'd212, 8'd213};
		foreach (hues[i])
			send_pixel(hues[i], 8'd255);
	endtask

	// No saturation gives white; small and mid saturations exercise rounding.
	task automatic test_gray_and_mid_sat();
		send_pixel(8'd100, 8'd0);
		send_pixel(8'd200, 8'd0);
		send_pixel(8'd30,  8'd1);
		send_pixel(8'd64,  8'd128);
	endtask

	// Random pixels in stretches, each stretch with its own idling mix
	// (including stretches with none on either side).
	task automatic test_random_pixels();
		level_t      hue;
		level_t      sat;
		int unsigned mix;
		for (int unsigned n = 0; n < RandomPixels; n++) begin
			if (n % StretchLen == 0) begin
				mix       = $urandom_range(0, 3);
				src_idle  = mix[0];
				sink_idle = mix[1];
			end
			hue = level_t'($urandom_range(0, 255));
			case ($urandom_range(0, 7))
				0:       sat = 8'd0;
				1:       sat = 8'd255;
				default: sat = level_t'($urandom_range(0, 255));
			endcase
			send_pixel(hue, sat);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_hue_extremes();
		test_sector_walk();
		test_gray_and_mid_sat();
		test_random_pixels();
		s_tvalid <= 1'b0;

		while (expected_rgb_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
